// File: design/lcbb_pkg.sv
// Package for the byte-budget LRU cache: payload structs, codes, FSM states and defaults.
// No dependencies; every design file imports it.
package lcbb_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam logic [31:0] MAX_BYTES_RST = 32'd67108864;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_EVICT  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_TOOBIG  = 2'd2;
  localparam logic [1:0] ST_NOROOM  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] handle;
    logic [31:0] item_bytes;
    logic        pinned;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        hit;
    logic [31:0] out_handle;
    logic [31:0] out_bytes;
    logic [1:0]  status;
    logic        last;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_PINCHK, S_EVCHK, S_EVICT, S_INSERT, S_OUT
  } state_t;

endpackage

// File: design/lru_cache_byte_budget_top.sv
// A keyed cache of up to ENTRIES handles under a byte budget with LRU eviction.
// A single sequencer walks the entry table one slot a cycle through one shared adder and
// comparator. A lookup, or an insert refused for a present key or excess size, ends after
// the scan and decide steps; a no-room refusal in the pinned-bytes check adds that step; an
// insert that passes it rescans the table after each eviction; a clear answers from idle.
// Each result is one beat on the out_ channel; the last beat of an item carries last, and a
// result that waits holds off the next input beat.
module lru_cache_byte_budget_top import lcbb_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data
);

  lcbb_top_ctl #(.ENTRIES(ENTRIES)) u_ctl (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: design/lcbb_top_ctl.sv
// Sequencer and entry table of the byte-budget LRU cache.
// Depends on lcbb_pkg; one shared 33-bit adder/comparator walks the table one entry a cycle.
module lcbb_top_ctl import lcbb_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic [ENTRIES-1:0] pin_r, pin_nxt;
  logic [31:0] key_r [ENTRIES];
  logic [31:0] hdl_r [ENTRIES];
  logic [31:0] byt_r [ENTRIES];
  logic [IW-1:0] rec_r [ENTRIES];

  logic [31:0] maxb_r, used_r, used_nxt;
  state_t      st_r, st_nxt;
  in_beat_t    req_r, req_nxt;
  out_beat_t   ob_r, ob_nxt;
  logic        ov_r, ov_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic [CW-1:0] pcnt_r, pcnt_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt;
  logic        fnd_r, fnd_nxt;
  logic [IW-1:0] hit_r, hit_nxt;
  logic        freef_r, freef_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic        vict_f_r, vict_f_nxt;
  logic [IW-1:0] vict_r, vict_nxt;
  logic        last_idx;

  logic        upd_rank, upd_evict, do_ins, do_clr;
  logic [IW-1:0] ins_rec;

  logic [32:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  assign last_idx = (idx_r == IW'(ENTRIES - 1));
  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = ob_r;

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; ob_nxt = ob_r; ov_nxt = ov_r;
    idx_nxt = idx_r; acc_nxt = acc_r; pcnt_nxt = pcnt_r; ucnt_nxt = ucnt_r;
    fnd_nxt = fnd_r; hit_nxt = hit_r; freef_nxt = freef_r; free_nxt = free_r;
    vict_f_nxt = vict_f_r; vict_nxt = vict_r; used_nxt = used_r;
    upd_rank = 1'b0; upd_evict = 1'b0; do_ins = 1'b0; do_clr = 1'b0;
    ins_rec = '0;
    add_a = acc_r; add_b = 33'd0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data;
          idx_nxt = '0; acc_nxt = '0; pcnt_nxt = '0; ucnt_nxt = '0;
          fnd_nxt = 1'b0; freef_nxt = 1'b0; vict_f_nxt = 1'b0;
          priority case (in_data.action)
            ACT_CLEAR: begin
              do_clr = 1'b1; used_nxt = '0;
              ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_OK, 1'b1};
              ov_nxt = 1'b1;
            end
            ACT_LOOKUP, ACT_INSERT: st_nxt = S_SCAN;
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (vld_r[idx_r]) begin
          if (key_r[idx_r] == req_r.key && !fnd_nxt) begin
            fnd_nxt = 1'b1; hit_nxt = idx_r;
          end
          if (pin_r[idx_r]) begin
            add_b = {1'b0, byt_r[idx_r]};
            acc_nxt = add_s;
            pcnt_nxt = pcnt_r + CW'(1);
          end else begin
            ucnt_nxt = ucnt_r + CW'(1);
            if (rec_r[idx_r] == '0) begin
              vict_f_nxt = 1'b1; vict_nxt = idx_r;
            end
          end
        end else if (!freef_r) begin
          freef_nxt = 1'b1; free_nxt = idx_r;
        end
        idx_nxt = idx_r + IW'(1);
        if (last_idx) st_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        ov_nxt = 1'b1;
        if (req_r.action == ACT_LOOKUP) begin
          if (fnd_r) begin
            upd_rank = !pin_r[hit_r];
            ob_nxt = '{KIND_LOOKUP, 1'b1, hdl_r[hit_r], byt_r[hit_r], ST_OK, 1'b1};
          end else begin
            ob_nxt = '{KIND_LOOKUP, 1'b0, 32'd0, 32'd0, ST_OK, 1'b1};
          end
          st_nxt = S_IDLE;
        end else if (fnd_r) begin
          ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_PRESENT, 1'b1};
          st_nxt = S_IDLE;
        end else if (req_r.item_bytes > maxb_r) begin
          ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_TOOBIG, 1'b1};
          st_nxt = S_IDLE;
        end else begin
          ov_nxt = ov_r && !out_ready;
          st_nxt = S_PINCHK;
        end
      end
      S_PINCHK: begin
        add_b = {1'b0, req_r.item_bytes};
        if (add_s > {1'b0, maxb_r} || pcnt_r >= CW'(ENTRIES)) begin
          ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_NOROOM, 1'b1};
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          st_nxt = S_EVCHK;
        end
      end
      S_EVCHK: begin
        add_a = {1'b0, used_r}; add_b = {1'b0, req_r.item_bytes};
        if (freef_r && add_s <= {1'b0, maxb_r}) begin
          st_nxt = S_INSERT;
        end else if (!vict_f_r) begin
          if (!ov_r || out_ready) begin
            ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_NOROOM, 1'b1};
            ov_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end else if (!ov_r || out_ready) begin
          ob_nxt = '{KIND_EVICT, 1'b0, hdl_r[vict_r], byt_r[vict_r], ST_OK, 1'b0};
          ov_nxt = 1'b1;
          upd_evict = 1'b1;
          used_nxt = used_r - byt_r[vict_r];
          ucnt_nxt = ucnt_r - CW'(1);
          idx_nxt = '0; freef_nxt = 1'b0; vict_f_nxt = 1'b0;
          st_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        if (!vld_r[idx_r]) begin
          if (!freef_r) begin
            freef_nxt = 1'b1; free_nxt = idx_r;
          end
        end else if (!pin_r[idx_r] && rec_r[idx_r] == '0) begin
          vict_f_nxt = 1'b1; vict_nxt = idx_r;
        end
        idx_nxt = idx_r + IW'(1);
        if (last_idx) st_nxt = S_EVCHK;
      end
      S_INSERT: begin
        if (!ov_r || out_ready) begin
          do_ins = 1'b1;
          ins_rec = req_r.pinned ? '0 : ucnt_r[IW-1:0];
          used_nxt = used_r + req_r.item_bytes;
          ob_nxt = '{KIND_STATUS, 1'b0, 32'd0, 32'd0, ST_OK, 1'b1};
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r; pin_nxt = pin_r;
    if (do_clr) vld_nxt = '0;
    if (upd_evict) vld_nxt[vict_r] = 1'b0;
    if (do_ins) begin
      vld_nxt[free_r] = 1'b1; pin_nxt[free_r] = req_r.pinned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; vld_r <= '0; used_r <= '0;
      maxb_r <= MAX_BYTES_RST;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; vld_r <= vld_nxt; used_r <= used_nxt;
      if (cfg_we) maxb_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pin_r <= pin_nxt; req_r <= req_nxt; ob_r <= ob_nxt; idx_r <= idx_nxt;
    acc_r <= acc_nxt; pcnt_r <= pcnt_nxt; ucnt_r <= ucnt_nxt; fnd_r <= fnd_nxt;
    hit_r <= hit_nxt; freef_r <= freef_nxt; free_r <= free_nxt;
    vict_f_r <= vict_f_nxt; vict_r <= vict_nxt;
    for (int i = 0; i < ENTRIES; i++) begin
      if (upd_rank && vld_r[i] && !pin_r[i]) begin
        if (IW'(i) == hit_r) rec_r[i] <= IW'(ucnt_r - CW'(1));
        else if (rec_r[i] > rec_r[hit_r]) rec_r[i] <= rec_r[i] - IW'(1);
      end
      if (upd_evict && vld_r[i] && !pin_r[i] && IW'(i) != vict_r &&
          rec_r[i] > rec_r[vict_r]) rec_r[i] <= rec_r[i] - IW'(1);
      if (do_ins && IW'(i) == free_r) begin
        key_r[i] <= req_r.key; hdl_r[i] <= req_r.handle;
        byt_r[i] <= req_r.item_bytes; rec_r[i] <= ins_rec;
      end
    end
  end

endmodule
